// ===== rtl/lrb_pkg.sv =====
// Shared types, codes and reset constants for the link reconnect supervisor.
// No dependencies; every other file imports this package.
package lrb_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int NOW_W         = 32;
  localparam int BACKOFF_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] FLOOR_RST   = 32'd1000;
  localparam logic [CFG_W-1:0] CAP_RST     = 32'd60000;
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 32'd15000;

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_POLL  = 1'b1;

  localparam logic [1:0] PHASE_CODE_IDLE       = 2'd0;
  localparam logic [1:0] PHASE_CODE_CONNECTING = 2'd1;
  localparam logic [1:0] PHASE_CODE_CONNECTED  = 2'd2;
  localparam logic [1:0] PHASE_CODE_DISCONN    = 2'd3;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_LOST    = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_CONNECTING = 4'b0010,
    PH_CONNECTED  = 4'b0100,
    PH_DISCONN    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] backoff_floor_ms;
    logic [CFG_W-1:0] backoff_cap_ms;
    logic [CFG_W-1:0] connect_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [NOW_W-1:0] now_ms;
    logic             link_up;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           link_phase_out;
    logic                 is_connected;
    logic [BACKOFF_W-1:0] backoff_report;
    logic                 start_radio;
    logic                 drop_radio;
    logic [1:0]           retry_cause;
  } res_word_t;

endpackage

// ===== rtl/lrb_if.sv =====
// Valid/ready channel interfaces for request words and result words.
// Depends on lrb_pkg for field widths.
interface lrb_in_if
  import lrb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [NOW_W-1:0] now_ms;
  logic             link_up;

  modport source (output valid, output req_type, output now_ms, output link_up, input ready);
  modport sink   (input valid, input req_type, input now_ms, input link_up, output ready);
endinterface

interface lrb_out_if
  import lrb_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           link_phase_out;
  logic                 is_connected;
  logic [BACKOFF_W-1:0] backoff_report;
  logic                 start_radio;
  logic                 drop_radio;
  logic [1:0]           retry_cause;

  modport source (output valid, output link_phase_out, output is_connected,
                  output backoff_report, output start_radio, output drop_radio,
                  output retry_cause, input ready);
  modport sink   (input valid, input link_phase_out, input is_connected,
                  input backoff_report, input start_radio, input drop_radio,
                  input retry_cause, output ready);
endinterface

// ===== rtl/lrb_cfg_regs.sv =====
// Configuration register bank: floor, cap and connect timeout.
// Depends on lrb_pkg.
module lrb_cfg_regs
  import lrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_FLOOR:   cfg_nxt.backoff_floor_ms   = cfg_wdata;
        CFG_IDX_CAP:     cfg_nxt.backoff_cap_ms     = cfg_wdata;
        CFG_IDX_TIMEOUT: cfg_nxt.connect_timeout_ms = cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backoff_floor_ms   <= FLOOR_RST;
      cfg_r.backoff_cap_ms     <= CAP_RST;
      cfg_r.connect_timeout_ms <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/lrb_fsm.sv =====
// Link phase state machine with backoff, timeout and retry scheduling.
// Depends on lrb_pkg; one word is evaluated per cycle when step is high.
module lrb_fsm
  import lrb_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  output res_word_t res
);

  // compare width covers both the time base and the 32-bit registers
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  phase_t                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0]   start_r, start_nxt;
  logic [TIME_BITS-1:0]   retry_r, retry_nxt;
  logic [BACKOFF_W-1:0]   backoff_r, backoff_nxt;

  logic [CW-1:0]          now_w, bo_w, elapsed_w, tmo_w;
  logic [TIME_BITS-1:0]   now_t, elapsed, since_retry, bo_plan_t;
  logic [BACKOFF_W-1:0]   bo_plan;
  logic [BACKOFF_W:0]     twice;
  logic                   started, dropped;
  logic [1:0]             cause;

  assign now_w       = CW'(in_word.now_ms);
  assign now_t       = now_w[TIME_BITS-1:0];
  assign elapsed     = now_t - start_r;
  assign since_retry = now_t - retry_r;
  assign elapsed_w   = CW'(elapsed);
  assign tmo_w       = CW'(cfg.connect_timeout_ms);

  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    retry_nxt   = retry_r;
    backoff_nxt = backoff_r;
    started     = 1'b0;
    dropped     = 1'b0;
    cause       = CAUSE_NONE;
    bo_plan     = backoff_r;

    if (in_word.req_type == REQ_BEGIN) begin
      if (phase_r == PH_IDLE) begin
        phase_nxt = PH_CONNECTING;
        start_nxt = now_t;
        started   = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: ;
        PH_CONNECTING: begin
          if (in_word.link_up) begin
            phase_nxt   = PH_CONNECTED;
            backoff_nxt = cfg.backoff_floor_ms;
          end else if (elapsed_w >= tmo_w) begin
            dropped = 1'b1;
            cause   = CAUSE_TIMEOUT;
          end
        end
        PH_CONNECTED: begin
          if (!in_word.link_up) begin
            bo_plan = cfg.backoff_floor_ms;  // fresh outage restarts from floor
            dropped = 1'b1;
            cause   = CAUSE_LOST;
          end
        end
        PH_DISCONN: begin
          if (!since_retry[TIME_BITS-1]) begin
            phase_nxt = PH_CONNECTING;
            start_nxt = now_t;
            started   = 1'b1;
          end
        end
        default: ;
      endcase
    end

    bo_w      = CW'(bo_plan);
    bo_plan_t = bo_w[TIME_BITS-1:0];
    twice     = {bo_plan, 1'b0};
    if (dropped) begin
      phase_nxt   = PH_DISCONN;
      retry_nxt   = now_t + bo_plan_t;
      backoff_nxt = (twice > {1'b0, cfg.backoff_cap_ms}) ? cfg.backoff_cap_ms
                                                         : twice[BACKOFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      start_r   <= '0;
      retry_r   <= '0;
      backoff_r <= FLOOR_RST;
    end else if (step) begin
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      retry_r   <= retry_nxt;
      backoff_r <= backoff_nxt;
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_IDLE:       res.link_phase_out = PHASE_CODE_IDLE;
      PH_CONNECTING: res.link_phase_out = PHASE_CODE_CONNECTING;
      PH_CONNECTED:  res.link_phase_out = PHASE_CODE_CONNECTED;
      PH_DISCONN:    res.link_phase_out = PHASE_CODE_DISCONN;
      default:       res.link_phase_out = PHASE_CODE_IDLE;
    endcase
    res.is_connected   = (phase_nxt == PH_CONNECTED);
    res.backoff_report = (phase_nxt == PH_CONNECTED) ? '0 : backoff_nxt;
    res.start_radio    = started;
    res.drop_radio     = dropped;
    res.retry_cause    = cause;
  end

  a_no_start_and_drop: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(res.start_radio && res.drop_radio))
    else $error("start and drop in the same word");

  a_drop_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.drop_radio |-> res.retry_cause != CAUSE_NONE)
    else $error("drop without a retry cause");

  a_drop_to_disconn: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.drop_radio |=> phase_r == PH_DISCONN)
    else $error("drop did not leave phase disconnected");

  a_connect_floor: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_CONNECTING && in_word.req_type == REQ_POLL && in_word.link_up
    |=> phase_r == PH_CONNECTED && backoff_r == $past(cfg.backoff_floor_ms))
    else $error("backoff not back at floor on connect");

endmodule

// ===== rtl/link_reconnect_backoff_fsm.sv =====
// Link reconnect supervisor with exponential backoff. Request words enter an
// input register, are evaluated combinationally against the phase state and
// land in a result register: one word per clock sustained while out_ch.ready
// holds. A request word moves from the input register into the result
// register once the result register is empty or being drained, and its result
// word is presented from there. Both ready paths follow out_ch.ready so
// a full result register stalls the input only when it is not being drained.
// Times compare modulo 2^TIME_BITS; configuration writes take effect at once,
// but a new floor acts only on the next floor reload, never directly on the running backoff.
module link_reconnect_backoff_fsm
  import lrb_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lrb_in_if.sink               in_ch,
  lrb_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t      cfg;
  res_word_t res;
  in_word_t  s1_word_r;
  res_word_t out_word_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      adv, take;

  lrb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lrb_fsm #(.TIME_BITS(TIME_BITS)) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .in_word (s1_word_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign take         = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = take || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_word_r.req_type <= in_ch.req_type;
      s1_word_r.now_ms   <= in_ch.now_ms;
      s1_word_r.link_up  <= in_ch.link_up;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.link_phase_out = out_word_r.link_phase_out;
  assign out_ch.is_connected   = out_word_r.is_connected;
  assign out_ch.backoff_report = out_word_r.backoff_report;
  assign out_ch.start_radio    = out_word_r.start_radio;
  assign out_ch.drop_radio     = out_word_r.drop_radio;
  assign out_ch.retry_cause    = out_word_r.retry_cause;

endmodule
